// ===== rtl/grfa_pkg.sv =====
// ----------------------------------------------------------------------------
// grfa_pkg
// Field widths, operation codes and types for the grid rectangle allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package grfa_pkg;

  localparam int OP_W     = 2;
  localparam int SLOT_W   = 5;
  localparam int WIDTH_W  = 4;
  localparam int HEIGHT_W = 3;
  localparam int TAG_W    = 16;

  typedef logic [OP_W-1:0]     op_t;
  typedef logic [SLOT_W-1:0]   slot_t;
  typedef logic [WIDTH_W-1:0]  width_t;
  typedef logic [HEIGHT_W-1:0] height_t;
  typedef logic [TAG_W-1:0]    tag_t;

  localparam op_t OP_INSERT = 2'd0;
  localparam op_t OP_PLACE  = 2'd1;
  localparam op_t OP_REMOVE = 2'd2;

endpackage

`default_nettype wire

// ===== rtl/grid_rectangle_first_fit_allocator.sv =====
// ----------------------------------------------------------------------------
// Operation: insert walks the anchors in order up to the chosen anchor, or
//   through every cell when nothing fits; place and remove walk up to the
//   slot. The anchor walk counter steps one cell a cycle through the shared
//   rectangle mask and overlap check; the result waits while the output stalls.
// Throughput: one item at a time; the next one is taken once the result is
//   registered. Reset (rst_n low, synchronous) frees every cell and anchor.
// ----------------------------------------------------------------------------
// grid_rectangle_first_fit_allocator
// First-fit rectangle allocator on an occupancy grid with per-anchor records.
// ----------------------------------------------------------------------------
`default_nettype none

module grid_rectangle_first_fit_allocator #(
  parameter int GRID_COLUMNS = 8,
  parameter int GRID_ROWS    = 4
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              in_valid,
  output logic                             in_stall,
  input  wire  [grfa_pkg::OP_W-1:0]        in_operation,
  input  wire  [grfa_pkg::SLOT_W-1:0]      in_slot,
  input  wire  [grfa_pkg::WIDTH_W-1:0]     in_item_width,
  input  wire  [grfa_pkg::HEIGHT_W-1:0]    in_item_height,
  input  wire  [grfa_pkg::TAG_W-1:0]       in_item_tag,
  output logic                             out_valid,
  input  wire                              out_stall,
  output logic [grfa_pkg::SLOT_W-1:0]      out_result_slot,
  output logic                             out_success,
  output logic [grfa_pkg::TAG_W-1:0]       out_removed_tag
);

  localparam int CELLS   = GRID_COLUMNS * GRID_ROWS;
  localparam int IDX_W   = $clog2(CELLS);
  localparam int COL_W   = $clog2(GRID_COLUMNS);
  localparam int ROW_W   = $clog2(GRID_ROWS);
  localparam int CNT_W   = $clog2(CELLS + 1);
  localparam int CMP_W   = (CNT_W > grfa_pkg::SLOT_W) ? CNT_W : grfa_pkg::SLOT_W;
  localparam int CSUM_W  = ((COL_W > grfa_pkg::WIDTH_W) ? COL_W : grfa_pkg::WIDTH_W) + 1;
  localparam int RSUM_W  = ((ROW_W > grfa_pkg::HEIGHT_W) ? ROW_W : grfa_pkg::HEIGHT_W) + 1;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;

  logic                state_r;
  grfa_pkg::op_t       op_r;
  logic                nop_r;
  logic [IDX_W-1:0]    slot_idx_r;
  grfa_pkg::width_t    w_r;
  grfa_pkg::height_t   h_r;
  grfa_pkg::tag_t      tag_r;
  logic [IDX_W-1:0]    idx_r;
  logic [COL_W-1:0]    col_r;
  logic [ROW_W-1:0]    row_r;
  logic [CELLS-1:0]    busy_r;
  logic [CELLS-1:0]    valid_r;

  grfa_pkg::width_t    anchor_width_mem  [CELLS];
  grfa_pkg::height_t   anchor_height_mem [CELLS];
  grfa_pkg::tag_t      anchor_tag_mem    [CELLS];
  grfa_pkg::width_t    rd_w_r;
  grfa_pkg::height_t   rd_h_r;
  grfa_pkg::tag_t      rd_tag_r;

  logic                out_valid_r;
  grfa_pkg::slot_t     out_slot_r;
  logic                out_success_r;
  grfa_pkg::tag_t      out_tag_r;

  logic                accept;
  logic                slot_in_range;
  logic                nop_in;
  grfa_pkg::width_t    cur_w;
  grfa_pkg::height_t   cur_h;
  logic [CSUM_W-1:0]   col_end;
  logic [RSUM_W-1:0]   row_end;
  logic                in_bounds;
  logic [CELLS-1:0]    rect_mask;
  logic                fits;
  logic                at_slot;
  logic                last;
  logic                hit;
  logic                finish;
  logic                out_free;
  logic                commit;

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;

  assign slot_in_range = (CMP_W'(in_slot) < CMP_W'(CELLS));

  always_comb begin
    unique case (in_operation) inside
      grfa_pkg::OP_INSERT:                      nop_in = 1'b0;
      grfa_pkg::OP_PLACE, grfa_pkg::OP_REMOVE:  nop_in = !slot_in_range;
      default:                                  nop_in = 1'b1;
    endcase
  end

  // shared rectangle unit: stored dims for remove, request dims otherwise
  assign cur_w   = (op_r == grfa_pkg::OP_REMOVE) ? rd_w_r : w_r;
  assign cur_h   = (op_r == grfa_pkg::OP_REMOVE) ? rd_h_r : h_r;
  assign col_end = CSUM_W'(col_r) + CSUM_W'(cur_w);
  assign row_end = RSUM_W'(row_r) + RSUM_W'(cur_h);

  assign in_bounds = (cur_w != '0) && (cur_h != '0) &&
                     (col_end <= CSUM_W'(GRID_COLUMNS)) &&
                     (row_end <= RSUM_W'(GRID_ROWS));

  always_comb begin
    for (int r = 0; r < GRID_ROWS; r++) begin
      for (int c = 0; c < GRID_COLUMNS; c++) begin
        rect_mask[r*GRID_COLUMNS + c] =
          (CSUM_W'(c) >= CSUM_W'(col_r)) && (CSUM_W'(c) < col_end) &&
          (RSUM_W'(r) >= RSUM_W'(row_r)) && (RSUM_W'(r) < row_end);
      end
    end
  end

  assign fits    = in_bounds && ((busy_r & rect_mask) == '0);
  assign at_slot = (idx_r == slot_idx_r);
  assign last    = (idx_r == IDX_W'(CELLS - 1));

  always_comb begin
    case (op_r)
      grfa_pkg::OP_INSERT: begin
        hit    = !busy_r[idx_r] && fits;
        finish = hit || last;
      end
      grfa_pkg::OP_PLACE: begin
        hit    = at_slot && !valid_r[idx_r] && fits;
        finish = at_slot;
      end
      grfa_pkg::OP_REMOVE: begin
        hit    = at_slot && valid_r[idx_r];
        finish = at_slot;
      end
      default: begin
        hit    = 1'b0;
        finish = 1'b1;
      end
    endcase
    if (nop_r) begin
      hit    = 1'b0;
      finish = 1'b1;
    end
  end

  assign out_free = !out_valid_r || !out_stall;
  assign commit   = (state_r == ST_SCAN) && finish && out_free;

  // control and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      busy_r      <= '0;
      valid_r     <= '0;
    end else begin
      if (accept) begin
        state_r <= ST_SCAN;
      end else if (commit) begin
        state_r <= ST_IDLE;
      end

      if (commit) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end

      if (commit && hit) begin
        if (op_r == grfa_pkg::OP_REMOVE) begin
          busy_r         <= busy_r & ~rect_mask;
          valid_r[idx_r] <= 1'b0;
        end else begin
          busy_r         <= busy_r | rect_mask;
          valid_r[idx_r] <= 1'b1;
        end
      end
    end
  end

  // item registers and anchor walk
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r       <= in_operation;
      nop_r      <= nop_in;
      slot_idx_r <= IDX_W'(in_slot);
      w_r        <= in_item_width;
      h_r        <= in_item_height;
      tag_r      <= in_item_tag;
      idx_r      <= '0;
      col_r      <= '0;
      row_r      <= '0;
    end else if ((state_r == ST_SCAN) && !finish) begin
      idx_r <= idx_r + 1'b1;
      if (col_r == COL_W'(GRID_COLUMNS - 1)) begin
        col_r <= '0;
        row_r <= row_r + 1'b1;
      end else begin
        col_r <= col_r + 1'b1;
      end
    end
  end

  // anchor records
  always_ff @(posedge clk) begin
    if (commit && hit && (op_r != grfa_pkg::OP_REMOVE)) begin
      anchor_width_mem[idx_r]  <= w_r;
      anchor_height_mem[idx_r] <= h_r;
      anchor_tag_mem[idx_r]    <= tag_r;
    end
    if (accept) begin
      rd_w_r   <= anchor_width_mem[IDX_W'(in_slot)];
      rd_h_r   <= anchor_height_mem[IDX_W'(in_slot)];
      rd_tag_r <= anchor_tag_mem[IDX_W'(in_slot)];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (commit) begin
      out_slot_r    <= hit ? grfa_pkg::SLOT_W'(idx_r) : '0;
      out_success_r <= hit;
      out_tag_r     <= (hit && (op_r == grfa_pkg::OP_REMOVE)) ? rd_tag_r : '0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_result_slot = out_slot_r;
  assign out_success     = out_success_r;
  assign out_removed_tag = out_tag_r;

endmodule

`default_nettype wire

// ===== dv/tb_grid_rectangle_first_fit_allocator.sv =====
// ----------------------------------------------------------------------------
// tb_grid_rectangle_first_fit_allocator
// Drives insert, place and remove items into the 8x4 grid allocator. A
// directed table covers the corner cases, then mostly well-formed random
// traffic follows. Each result item is checked against the table's expected
// result or a grid model kept in the bench, with random idling on both sides
// and one long output hold.
`default_nettype none

module tb_grid_rectangle_first_fit_allocator;

  localparam int COLS        = 8;
  localparam int ROWS        = 4;
  localparam int CELLS       = COLS * ROWS;
  localparam int DIR_N       = 24;
  localparam int RAND_N      = 1030;
  localparam int LONG_HOLD   = 300;
  localparam int CYCLE_LIMIT = 400000;

  // not defined in the package; the block returns all zero for it
  localparam grfa_pkg::op_t OP_NONE = 2'd3;

  typedef struct packed {
    grfa_pkg::op_t     op;
    grfa_pkg::slot_t   slot;
    grfa_pkg::width_t  w;
    grfa_pkg::height_t h;
    grfa_pkg::tag_t    tag;
  } alloc_req_t;

  typedef struct packed {
    grfa_pkg::slot_t slot;
    logic            ok;
    grfa_pkg::tag_t  rtag;
  } alloc_resp_t;

  typedef struct packed {
    alloc_req_t  req;
    logic        typed;
    alloc_resp_t resp;
  } dir_row_t;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  grfa_pkg::op_t     in_operation;
  grfa_pkg::slot_t   in_slot;
  grfa_pkg::width_t  in_item_width;
  grfa_pkg::height_t in_item_height;
  grfa_pkg::tag_t    in_item_tag;
  logic              out_valid;
  logic              out_stall;
  grfa_pkg::slot_t   out_result_slot;
  logic              out_success;
  grfa_pkg::tag_t    out_removed_tag;

  grid_rectangle_first_fit_allocator #(
    .GRID_COLUMNS(COLS),
    .GRID_ROWS   (ROWS)
  ) u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_operation   (in_operation),
    .in_slot        (in_slot),
    .in_item_width  (in_item_width),
    .in_item_height (in_item_height),
    .in_item_tag    (in_item_tag),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_result_slot(out_result_slot),
    .out_success    (out_success),
    .out_removed_tag(out_removed_tag)
  );

  // grid model
  bit                cell_busy [CELLS];
  bit                anchor_used [CELLS];
  grfa_pkg::width_t  anchor_w [CELLS];
  grfa_pkg::height_t anchor_h [CELLS];
  grfa_pkg::tag_t    anchor_tag [CELLS];

  alloc_resp_t expected_q [$];
  alloc_resp_t got_resp;
  int          n_fail    = 0;
  int          cycle_cnt = 0;
  bit          idle_en   = 1'b1;
  bit          hold_req  = 1'b0;

  dir_row_t dir_tab [DIR_N] = '{
    '{'{grfa_pkg::OP_INSERT, 5'd0, 4'd8, 3'd4, 16'hFFFF}, 1'b1, '{5'd0, 1'b1, 16'h0000}},
    '{'{grfa_pkg::OP_INSERT, 5'd5, 4'd1, 3'd1, 16'h0001}, 1'b1, '{5'd0, 1'b0, 16'h0000}},
    '{'{grfa_pkg::OP_PLACE, 5'd31, 4'd1, 3'd1, 16'h0002}, 1'b1, '{5'd0, 1'b0, 16'h0000}},
    '{'{grfa_pkg::OP_REMOVE, 5'd0, 4'd0, 3'd0, 16'h0000}, 1'b1, '{5'd0, 1'b1, 16'hFFFF}},
    '{'{grfa_pkg::OP_REMOVE, 5'd0, 4'd0, 3'd0, 16'h0000}, 1'b1, '{5'd0, 1'b0, 16'h0000}},
    '{'{grfa_pkg::OP_INSERT, 5'd0, 4'd0, 3'd1, 16'h0003}, 1'b1, '{5'd0, 1'b0, 16'h0000}},
    '{'{grfa_pkg::OP_INSERT, 5'd0, 4'd1, 3'd0, 16'h0004}, 1'b1, '{5'd0, 1'b0, 16'h0000}},
    '{'{grfa_pkg::OP_INSERT, 5'd31, 4'd15, 3'd7, 16'h0005}, 1'b1, '{5'd0, 1'b0, 16'h0000}},
    '{'{grfa_pkg::OP_PLACE, 5'd31, 4'd1, 3'd1, 16'h1234}, 1'b1, '{5'd31, 1'b1, 16'h0000}},
    '{'{grfa_pkg::OP_PLACE, 5'd31, 4'd1, 3'd1, 16'h5678}, 1'b1, '{5'd0, 1'b0, 16'h0000}},
    '{'{grfa_pkg::OP_PLACE, 5'd7, 4'd2, 3'd1, 16'h0009}, 1'b1, '{5'd0, 1'b0, 16'h0000}},
    '{'{grfa_pkg::OP_PLACE, 5'd24, 4'd1, 3'd2, 16'h000A}, 1'b1, '{5'd0, 1'b0, 16'h0000}},
    '{'{OP_NONE, 5'd31, 4'd15, 3'd7, 16'hFFFF}, 1'b1, '{5'd0, 1'b0, 16'h0000}},
    '{'{grfa_pkg::OP_INSERT, 5'd0, 4'd3, 3'd2, 16'h00A0}, 1'b0, '0},
    '{'{grfa_pkg::OP_INSERT, 5'd0, 4'd2, 3'd2, 16'h00A1}, 1'b0, '0},
    '{'{grfa_pkg::OP_PLACE, 5'd1, 4'd1, 3'd1, 16'h00A2}, 1'b0, '0},
    '{'{grfa_pkg::OP_PLACE, 5'd30, 4'd1, 3'd1, 16'h00A3}, 1'b0, '0},
    '{'{grfa_pkg::OP_REMOVE, 5'd31, 4'd0, 3'd0, 16'h0000}, 1'b0, '0},
    '{'{grfa_pkg::OP_REMOVE, 5'd0, 4'd0, 3'd0, 16'h0000}, 1'b0, '0},
    '{'{grfa_pkg::OP_INSERT, 5'd0, 4'd8, 3'd1, 16'h00A4}, 1'b0, '0},
    '{'{grfa_pkg::OP_INSERT, 5'd0, 4'd1, 3'd4, 16'h00A5}, 1'b0, '0},
    '{'{grfa_pkg::OP_REMOVE, 5'd3, 4'd0, 3'd0, 16'h0000}, 1'b0, '0},
    '{'{grfa_pkg::OP_REMOVE, 5'd30, 4'd0, 3'd0, 16'h0000}, 1'b0, '0},
    '{'{grfa_pkg::OP_PLACE, 5'd0, 4'd8, 3'd4, 16'h0000}, 1'b0, '0}
  };

  function automatic bit rect_free(int col, int row, int w, int h);
    if (w == 0 || h == 0) return 1'b0;
    if (col + w > COLS || row + h > ROWS) return 1'b0;
    for (int r = 0; r < h; r++)
      for (int c = 0; c < w; c++)
        if (cell_busy[(row + r) * COLS + col + c]) return 1'b0;
    return 1'b1;
  endfunction

  // clipped to the grid, as the stored size may run past the edge
  function automatic void mark_rect(int anchor, int w, int h, bit busy);
    int col;
    int row;
    col = anchor % COLS;
    row = anchor / COLS;
    for (int r = 0; r < h && row + r < ROWS; r++)
      for (int c = 0; c < w && col + c < COLS; c++)
        cell_busy[(row + r) * COLS + col + c] = busy;
  endfunction

  function automatic void store_rect(int anchor, alloc_req_t q);
    anchor_used[anchor] = 1'b1;
    anchor_w[anchor]    = q.w;
    anchor_h[anchor]    = q.h;
    anchor_tag[anchor]  = q.tag;
    mark_rect(anchor, q.w, q.h, 1'b1);
  endfunction

  // applies one item to the grid model and returns its result item
  function automatic alloc_resp_t apply_alloc(alloc_req_t q);
    alloc_resp_t res;
    bit          found;
    int          s;
    res   = '0;
    found = 1'b0;
    s     = q.slot;
    case (q.op)
      grfa_pkg::OP_INSERT: begin
        for (int i = 0; i < CELLS && !found; i++) begin
          if (!cell_busy[i] && rect_free(i % COLS, i / COLS, q.w, q.h)) begin
            store_rect(i, q);
            res.slot = grfa_pkg::slot_t'(i);
            res.ok   = 1'b1;
            found    = 1'b1;
          end
        end
      end
      grfa_pkg::OP_PLACE: begin
        if (s < CELLS && !anchor_used[s] && rect_free(s % COLS, s / COLS, q.w, q.h)) begin
          store_rect(s, q);
          res.slot = q.slot;
          res.ok   = 1'b1;
        end
      end
      grfa_pkg::OP_REMOVE: begin
        if (s < CELLS && anchor_used[s]) begin
          mark_rect(s, anchor_w[s], anchor_h[s], 1'b0);
          anchor_used[s] = 1'b0;
          res.rtag = anchor_tag[s];
          res.slot = q.slot;
          res.ok   = 1'b1;
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  // random anchor in use, or random free cell; -1 when there is none
  function automatic int pick_cell(bit want_anchor);
    int n;
    int k;
    n = 0;
    for (int i = 0; i < CELLS; i++)
      if (want_anchor ? anchor_used[i] : !cell_busy[i]) n++;
    if (n == 0) return -1;
    k = $urandom_range(0, n - 1);
    for (int i = 0; i < CELLS; i++) begin
      if (want_anchor ? anchor_used[i] : !cell_busy[i]) begin
        if (k == 0) return i;
        k--;
      end
    end
    return -1;
  endfunction

  // called at a falling edge; returns at the falling edge after accept
  task automatic send_item(alloc_req_t q, logic typed, alloc_resp_t typed_resp);
    alloc_resp_t pred;
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_operation   <= q.op;
    in_slot        <= q.slot;
    in_item_width  <= q.w;
    in_item_height <= q.h;
    in_item_tag    <= q.tag;
    do @(posedge clk); while (in_stall);
    pred = apply_alloc(q);
    expected_q.push_back(typed ? typed_resp : pred);
    @(negedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver side: short random holds, one long hold on request
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(negedge clk);
        out_stall <= 1'b0;
      end else if (idle_en && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 3)) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        n_fail++;
        $error("result item with nothing expected: slot %0d success %0b tag %h",
               out_result_slot, out_success, out_removed_tag);
      end else begin
        got_resp = expected_q.pop_front();
        if (out_result_slot !== got_resp.slot) begin
          n_fail++;
          $error("result_slot: expected %0d, actual %0d", got_resp.slot, out_result_slot);
        end
        if (out_success !== got_resp.ok) begin
          n_fail++;
          $error("success: expected %0b, actual %0b", got_resp.ok, out_success);
        end
        if (out_removed_tag !== got_resp.rtag) begin
          n_fail++;
          $error("removed_tag: expected %h, actual %h", got_resp.rtag, out_removed_tag);
        end
      end
    end
  end

  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("grid_rectangle_first_fit_allocator test failed");
    $finish;
  end

  initial begin
    alloc_req_t rq;
    int         r;
    int         a;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_operation   = grfa_pkg::OP_INSERT;
    in_slot        = '0;
    in_item_width  = '0;
    in_item_height = '0;
    in_item_tag    = '0;
    for (int i = 0; i < CELLS; i++) begin
      cell_busy[i]   = 1'b0;
      anchor_used[i] = 1'b0;
    end
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int i = 0; i < DIR_N; i++)
      send_item(dir_tab[i].req, dir_tab[i].typed, dir_tab[i].resp);

    for (int n = 0; n < RAND_N; n++) begin
      if (n == 300) hold_req = 1'b1;
      if (n == 650) begin
        // let the block drain completely before going on
        in_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge clk);
        @(negedge clk);
      end
      if (n == RAND_N - 150) idle_en = 1'b0;

      rq.op   = grfa_pkg::OP_INSERT;
      rq.slot = grfa_pkg::slot_t'($urandom_range(0, 31));
      rq.w    = grfa_pkg::width_t'($urandom_range(1, 4));
      rq.h    = grfa_pkg::height_t'($urandom_range(1, 2));
      rq.tag  = grfa_pkg::tag_t'($urandom_range(0, 16'hFFFF));
      r = $urandom_range(0, 99);
      if (r < 35) begin
        // insert, now and then a full-size rectangle
        if ($urandom_range(0, 9) == 0) rq.h = grfa_pkg::height_t'($urandom_range(1, 4));
        if ($urandom_range(0, 9) == 0) rq.w = grfa_pkg::width_t'($urandom_range(1, 8));
      end else if (r < 70) begin
        rq.op = grfa_pkg::OP_REMOVE;
        a = pick_cell(1'b1);
        if (a >= 0) rq.slot = grfa_pkg::slot_t'(a);
      end else if (r < 82) begin
        rq.op = grfa_pkg::OP_PLACE;
        a = pick_cell(1'b0);
        if (a >= 0) rq.slot = grfa_pkg::slot_t'(a);
      end else if (r < 90) begin
        rq.op = grfa_pkg::OP_REMOVE;
      end else if (r < 97) begin
        // noise over the full size and slot ranges
        rq.op = grfa_pkg::op_t'($urandom_range(0, 2));
        rq.w  = grfa_pkg::width_t'($urandom_range(0, 15));
        rq.h  = grfa_pkg::height_t'($urandom_range(0, 7));
      end else begin
        rq.op = OP_NONE;
        rq.w  = grfa_pkg::width_t'($urandom_range(0, 15));
        rq.h  = grfa_pkg::height_t'($urandom_range(0, 7));
      end
      send_item(rq, 1'b0, '0);
    end

    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (n_fail == 0)
      $display("grid_rectangle_first_fit_allocator test passed");
    else
      $display("grid_rectangle_first_fit_allocator test failed");
    $finish;
  end

endmodule

`default_nettype wire
